>>> hdl/hsm_pkg.sv
// shared types and constants of the hit to signal merger
`timescale 1ns / 1ps

package hsm_pkg;

    localparam int CHAN_W      = 16;
    localparam int TIME_W      = 32;
    localparam int ENERGY_W    = 16;
    localparam int AMP_W       = 32;
    localparam int WIN_W       = 32;
    localparam int IDX_OUT_W   = 6;
    localparam int AMP_FACTOR_W = 9;

    localparam logic [AMP_FACTOR_W-1:0] AMP_PER_ENERGY = 9'd300;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [ENERGY_W-1:0]  energy_t;
    typedef logic [AMP_W-1:0]     amp_t;
    typedef logic [WIN_W-1:0]     win_t;
    typedef logic [IDX_OUT_W-1:0] idx_out_t;

    typedef struct packed {
        chan_t chan;
        time_t start;
        amp_t  amp;
    } entry_t;

endpackage

>>> hdl/hsm_if.sv
// valid/ready channel interfaces for hits, results and configuration
`timescale 1ns / 1ps

interface hsm_hit_if;
    import hsm_pkg::*;

    logic    valid;
    logic    ready;
    logic    first_of_event;
    chan_t   channel_id;
    time_t   hit_time;
    energy_t hit_energy;

    modport source (output valid, output first_of_event, output channel_id,
                    output hit_time, output hit_energy, input ready);
    modport sink   (input valid, input first_of_event, input channel_id,
                    input hit_time, input hit_energy, output ready);
endinterface

interface hsm_res_if;
    import hsm_pkg::*;

    logic     valid;
    logic     ready;
    logic     merged;
    logic     dropped;
    idx_out_t signal_index;
    amp_t     signal_amplitude;
    time_t    signal_start;

    modport source (output valid, output merged, output dropped, output signal_index,
                    output signal_amplitude, output signal_start, input ready);
    modport sink   (input valid, input merged, input dropped, input signal_index,
                    input signal_amplitude, input signal_start, output ready);
endinterface

interface hsm_cfg_if;
    import hsm_pkg::*;

    logic valid;
    logic ready;
    win_t merge_window;

    modport source (output valid, output merge_window, input ready);
    modport sink   (input valid, input merge_window, output ready);
endinterface

>>> hdl/hsm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hsm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/hit_to_signal_merger_core.sv
// hit to signal merger: table walk, merge, append or drop, one result per hit
// a new hit is taken only in the idle state, after the walk and the write of the last
//   hit; the write waits while the result register is still full and ready is low;
//   the table walk reads one entry per cycle
// reset: entry count cleared and merge_window set to 0; table ram is not cleared,
//   entries above the count are never read
`timescale 1ns / 1ps

module hit_to_signal_merger_core #(
    parameter int MAX_SIGNALS = 64
) (
    input  logic clk,
    input  logic rst_n,
    hsm_hit_if.sink   hit,
    hsm_res_if.source result,
    hsm_cfg_if.sink   cfg
);
    import hsm_pkg::*;

    localparam int AW = $clog2(MAX_SIGNALS);
    localparam int CW = $clog2(MAX_SIGNALS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          chk_reg, chk_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          found_reg, found_next;
    logic [AW-1:0] pos_reg, pos_next;
    time_t         m_start_reg, m_start_next;
    amp_t          m_amp_reg, m_amp_next;
    win_t          window_reg;

    chan_t         chan_reg, chan_next;
    time_t         time_reg, time_next;
    amp_t          amp_reg, amp_next;

    logic          out_valid_reg, out_valid_next;
    logic          merged_reg, merged_next;
    logic          dropped_reg, dropped_next;
    idx_out_t      index_reg, index_next;
    amp_t          out_amp_reg, out_amp_next;
    time_t         out_start_reg, out_start_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    logic signed [TIME_W+1:0] limit;
    logic signed [TIME_W+1:0] hit_time_ext;
    logic                     match;
    logic [AMP_W:0]           sum;
    amp_t                     sum_sat;

    hsm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_SIGNALS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // shared compare unit: exact 34-bit start + window against hit time
    assign limit        = $signed({2'b00, ram_rdata.start})
                        + $signed({{2{window_reg[WIN_W-1]}}, window_reg});
    assign hit_time_ext = $signed({2'b00, time_reg});
    assign match        = (ram_rdata.chan == chan_reg) && (hit_time_ext <= limit);

    assign sum     = {1'b0, m_amp_reg} + {1'b0, amp_reg};
    assign sum_sat = sum[AMP_W] ? {AMP_W{1'b1}} : sum[AMP_W-1:0];

    assign hit.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign result.valid            = out_valid_reg;
    assign result.merged           = merged_reg;
    assign result.dropped          = dropped_reg;
    assign result.signal_index     = index_reg;
    assign result.signal_amplitude = out_amp_reg;
    assign result.signal_start     = out_start_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        m_start_next   = m_start_reg;
        m_amp_next     = m_amp_reg;
        chan_next      = chan_reg;
        time_next      = time_reg;
        amp_next       = amp_reg;
        out_valid_next = out_valid_reg;
        merged_next    = merged_reg;
        dropped_next   = dropped_reg;
        index_next     = index_reg;
        out_amp_next   = out_amp_reg;
        out_start_next = out_start_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = '{chan: chan_reg, start: time_reg, amp: amp_reg};

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (hit.valid)
                begin
                    chan_next  = hit.channel_id;
                    time_next  = hit.hit_time;
                    amp_next   = AMP_W'(hit.hit_energy) * AMP_W'(AMP_PER_ENERGY);
                    count_next = hit.first_of_event ? '0 : count_reg;
                    idx_next   = '0;
                    chk_next   = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_next = 1'b0;
                if (idx_reg < count_reg)
                begin
                    chk_next     = 1'b1;
                    chk_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                if (chk_reg && match)
                begin
                    found_next   = 1'b1;
                    pos_next     = chk_idx_reg;
                    m_start_next = ram_rdata.start;
                    m_amp_next   = ram_rdata.amp;
                end
                if ((idx_reg == count_reg) && !chk_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = pos_reg;
                        ram_wdata      = '{chan: chan_reg, start: m_start_reg, amp: sum_sat};
                        merged_next    = 1'b1;
                        dropped_next   = 1'b0;
                        index_next     = IDX_OUT_W'(pos_reg);
                        out_amp_next   = sum_sat;
                        out_start_next = m_start_reg;
                    end
                    else if (count_reg < CW'(MAX_SIGNALS))
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = count_reg[AW-1:0];
                        count_next     = count_reg + 1'b1;
                        merged_next    = 1'b0;
                        dropped_next   = 1'b0;
                        index_next     = IDX_OUT_W'(count_reg[AW-1:0]);
                        out_amp_next   = amp_reg;
                        out_start_next = time_reg;
                    end
                    else
                    begin
                        merged_next    = 1'b0;
                        dropped_next   = 1'b1;
                        index_next     = '0;
                        out_amp_next   = '0;
                        out_start_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                window_reg <= cfg.merge_window;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        pos_reg       <= pos_next;
        m_start_reg   <= m_start_next;
        m_amp_reg     <= m_amp_next;
        chan_reg      <= chan_next;
        time_reg      <= time_next;
        amp_reg       <= amp_next;
        merged_reg    <= merged_next;
        dropped_reg   <= dropped_next;
        index_reg     <= index_next;
        out_amp_reg   <= out_amp_next;
        out_start_reg <= out_start_next;
    end

endmodule

>>> tb/testbench.sv
// self-checking testbench of the hit to signal merger with a table predictor
`timescale 1ns / 1ps

module testbench;
    import hsm_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int IDLE_PCT     = 29;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int RANDOM_HITS  = 300;
    localparam int BURST_HITS   = 230;
    localparam int PLAN_ROWS    = 21;

    localparam amp_t AMP_SATURATED = '1;
    localparam win_t WINDOW_MAX    = 32'h7FFF_FFFF;
    localparam win_t WINDOW_MIN    = 32'h8000_0000;
    localparam win_t WINDOW_NEG1   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic     merged;
        logic     dropped;
        idx_out_t signal_index;
        amp_t     signal_amplitude;
        time_t    signal_start;
    } sig_result_t;

    typedef enum logic {ROW_HIT, ROW_CFG} row_kind_t;
    typedef enum logic {CHK_MODEL, CHK_TYPED} row_check_t;
    typedef enum int {WIN_ZERO, WIN_MAX, WIN_MIN, WIN_MINUS_ONE, WIN_SHORT, WIN_ANY} win_pick_t;

    typedef struct packed {
        row_kind_t   kind;
        win_t        window;
        logic [7:0]  reps;
        logic        first;
        chan_t       chan;
        time_t       stamp;
        energy_t     energy;
        row_check_t  check;
        sig_result_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    hsm_hit_if hit_ch ();
    hsm_res_if res_ch ();
    hsm_cfg_if cfg_ch ();

    hit_to_signal_merger_core #(
        .MAX_SIGNALS(TABLE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    int unsigned sig_count;
    chan_t       tbl_chan  [TABLE_DEPTH];
    time_t       tbl_start [TABLE_DEPTH];
    amp_t        tbl_amp   [TABLE_DEPTH];
    win_t        window_model;

    sig_result_t pending_results [$];
    plan_row_t   plan [PLAN_ROWS];

    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;
    int fail_count;
    int cycle_count;
    int directed_hits;
    int random_hits;
    int window_writes;
    int merged_count;
    int new_count;
    int dropped_count;

    function automatic sig_result_t fold_hit(logic first, chan_t ch, time_t t, energy_t e);
        amp_t        amp;
        logic [32:0] sum;
        longint      limit;
        bit          found;
        int          pos;
        sig_result_t r;
        amp = amp_t'(e) * amp_t'(AMP_PER_ENERGY);
        found = 1'b0;
        pos = 0;
        if (first)
            sig_count = 0;
        for (int i = 0; i < sig_count; i++)
        begin
            limit = longint'(tbl_start[i]) + longint'($signed(window_model));
            if (tbl_chan[i] == ch && longint'(t) <= limit)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        if (found)
        begin
            sum = {1'b0, tbl_amp[pos]} + {1'b0, amp};
            tbl_amp[pos] = sum[32] ? AMP_SATURATED : sum[31:0];
            r = '{1'b1, 1'b0, idx_out_t'(pos), tbl_amp[pos], tbl_start[pos]};
        end
        else if (sig_count < TABLE_DEPTH)
        begin
            pos = sig_count;
            tbl_chan[pos] = ch;
            tbl_start[pos] = t;
            tbl_amp[pos] = amp;
            sig_count++;
            r = '{1'b0, 1'b0, idx_out_t'(pos), amp, t};
        end
        else
            r = '{1'b0, 1'b1, '0, '0, '0};
        return r;
    endfunction

    function automatic plan_row_t hit_row(logic first, chan_t ch, time_t t, energy_t e,
                                          logic [7:0] reps, row_check_t chk,
                                          sig_result_t want);
        return '{ROW_HIT, '0, reps, first, ch, t, e, chk, want};
    endfunction

    function automatic plan_row_t cfg_row(win_t w);
        return '{ROW_CFG, w, 8'd0, 1'b0, '0, '0, '0, CHK_MODEL, '0};
    endfunction

    function automatic sig_result_t new_sig(idx_out_t idx, amp_t amp, time_t start);
        return '{1'b0, 1'b0, idx, amp, start};
    endfunction

    function automatic sig_result_t merged_sig(idx_out_t idx, amp_t amp, time_t start);
        return '{1'b1, 1'b0, idx, amp, start};
    endfunction

    function automatic sig_result_t dropped_sig();
        return '{1'b0, 1'b1, '0, '0, '0};
    endfunction

    // called and returns at a falling edge
    task automatic send_hit(logic first, chan_t ch, time_t t, energy_t e,
                            bit typed, sig_result_t want);
        sig_result_t r;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            hit_ch.valid <= 1'b0;
            @(negedge clk);
        end
        hit_ch.valid          <= 1'b1;
        hit_ch.first_of_event <= first;
        hit_ch.channel_id     <= ch;
        hit_ch.hit_time       <= t;
        hit_ch.hit_energy     <= e;
        do
            @(posedge clk);
        while (!hit_ch.ready);
        r = fold_hit(first, ch, t, e);
        pending_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic write_window(win_t w);
        hit_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.merge_window <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        window_model = w;
        window_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int n);
        win_pick_t pick;
        win_t      w;
        chan_t     pool [4];
        time_t     base;
        logic      first;
        chan_t     ch;
        time_t     t;
        energy_t   e;
        pick = win_pick_t'($urandom_range(WIN_ANY));
        case (pick)
            WIN_ZERO:      w = '0;
            WIN_MAX:       w = WINDOW_MAX;
            WIN_MIN:       w = WINDOW_MIN;
            WIN_MINUS_ONE: w = WINDOW_NEG1;
            WIN_SHORT:     w = win_t'($urandom_range(300));
            default:       w = $urandom;
        endcase
        write_window(w);
        base = '0;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 10)
            begin
                // noise
                first = 1'($urandom_range(1));
                ch = chan_t'($urandom);
                t = $urandom;
                e = energy_t'($urandom);
            end
            else
            begin
                first = (k == 0) || ($urandom_range(99) < 2);
                if (first)
                begin
                    foreach (pool[j])
                        pool[j] = chan_t'($urandom);
                    base = $urandom;
                end
                ch = pool[$urandom_range(3)];
                t = base + time_t'($urandom_range(400));
                base = base + time_t'($urandom_range(40));
                e = ($urandom_range(3) == 0) ? energy_t'($urandom)
                                             : energy_t'($urandom_range(255));
            end
            send_hit(first, ch, t, e, 1'b0, '0);
            random_hits++;
        end
    endtask

    // amplitude saturation on one channel
    task automatic run_burst();
        chan_t ch;
        ch = chan_t'($urandom);
        write_window(WINDOW_MAX);
        for (int k = 0; k < BURST_HITS; k++)
        begin
            send_hit(k == 0, ch, $urandom, energy_t'($urandom_range(16'hFFFF, 16'hF000)),
                     1'b0, '0);
            random_hits++;
        end
    endtask

    always @(negedge clk)
        res_ch.ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sig_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no hit pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.merged !== want.merged)
                begin
                    $error("merged: expected %0d, got %0d", want.merged, res_ch.merged);
                    fail_count++;
                end
                if (res_ch.dropped !== want.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", want.dropped, res_ch.dropped);
                    fail_count++;
                end
                if (res_ch.signal_index !== want.signal_index)
                begin
                    $error("signal_index: expected %0d, got %0d",
                           want.signal_index, res_ch.signal_index);
                    fail_count++;
                end
                if (res_ch.signal_amplitude !== want.signal_amplitude)
                begin
                    $error("signal_amplitude: expected %0d, got %0d",
                           want.signal_amplitude, res_ch.signal_amplitude);
                    fail_count++;
                end
                if (res_ch.signal_start !== want.signal_start)
                begin
                    $error("signal_start: expected %0d, got %0d",
                           want.signal_start, res_ch.signal_start);
                    fail_count++;
                end
                if (want.dropped)
                    dropped_count++;
                else if (want.merged)
                    merged_count++;
                else
                    new_count++;
            end
        end
    end

    initial
    begin
        hit_ch.valid          = 1'b0;
        hit_ch.first_of_event = 1'b0;
        hit_ch.channel_id     = '0;
        hit_ch.hit_time       = '0;
        hit_ch.hit_energy     = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.merge_window   = '0;
        res_ch.ready          = 1'b0;
        sig_count             = 0;
        window_model          = '0;

        plan = '{
            hit_row(1'b1, 16'h0000, 32'd100, 16'hFFFF, 8'd1, CHK_TYPED,
                    new_sig(6'd0, 32'd19660500, 32'd100)),
            hit_row(1'b0, 16'h0000, 32'd100, 16'h0001, 8'd1, CHK_TYPED,
                    merged_sig(6'd0, 32'd19660800, 32'd100)),
            hit_row(1'b0, 16'h0000, 32'd101, 16'h0001, 8'd1, CHK_TYPED,
                    new_sig(6'd1, 32'd300, 32'd101)),
            hit_row(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 8'd1, CHK_TYPED,
                    new_sig(6'd2, 32'd0, 32'hFFFF_FFFF)),
            hit_row(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd1, CHK_TYPED,
                    merged_sig(6'd2, 32'd19660500, 32'hFFFF_FFFF)),
            hit_row(1'b0, 16'h0000, 32'd0, 16'h0002, 8'd1, CHK_TYPED,
                    merged_sig(6'd1, 32'd900, 32'd101)),
            cfg_row(WINDOW_MAX),
            hit_row(1'b0, 16'hFFFF, 32'd0, 16'h0001, 8'd1, CHK_TYPED,
                    merged_sig(6'd2, 32'd19660800, 32'hFFFF_FFFF)),
            hit_row(1'b0, 16'h0000, 32'h8000_0063, 16'h1234, 8'd1, CHK_MODEL, '0),
            cfg_row(WINDOW_MIN),
            hit_row(1'b1, 16'h0007, 32'hFFFF_FFFF, 16'h0003, 8'd1, CHK_TYPED,
                    new_sig(6'd0, 32'd900, 32'hFFFF_FFFF)),
            hit_row(1'b0, 16'h0007, 32'h7FFF_FFFF, 16'h0003, 8'd1, CHK_TYPED,
                    merged_sig(6'd0, 32'd1800, 32'hFFFF_FFFF)),
            hit_row(1'b0, 16'h0007, 32'h8000_0000, 16'h0003, 8'd1, CHK_TYPED,
                    new_sig(6'd1, 32'd900, 32'h8000_0000)),
            hit_row(1'b0, 16'h0007, 32'd0, 16'h0003, 8'd1, CHK_TYPED,
                    merged_sig(6'd1, 32'd1800, 32'h8000_0000)),
            cfg_row(WINDOW_NEG1),
            hit_row(1'b1, 16'h0001, 32'd0, 16'h0004, 8'd1, CHK_TYPED,
                    new_sig(6'd0, 32'd1200, 32'd0)),
            hit_row(1'b0, 16'h0001, 32'd0, 16'h0004, 8'd1, CHK_TYPED,
                    new_sig(6'd1, 32'd1200, 32'd0)),
            // fill the whole table with distinct channels
            hit_row(1'b1, 16'h0100, 32'h0000_1000, 16'h00FF, 8'd64, CHK_MODEL, '0),
            hit_row(1'b0, 16'h0100, 32'h0000_1000, 16'h0001, 8'd1, CHK_TYPED, dropped_sig()),
            hit_row(1'b0, 16'h0105, 32'd0, 16'h0001, 8'd1, CHK_MODEL, '0),
            hit_row(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd1, CHK_TYPED, dropped_sig())
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CFG)
                write_window(plan[r].window);
            else
                for (int k = 0; k < plan[r].reps; k++)
                begin
                    send_hit(plan[r].first && (k == 0), plan[r].chan + chan_t'(k),
                             plan[r].stamp + time_t'(k), plan[r].energy,
                             plan[r].check == CHK_TYPED, plan[r].want);
                    directed_hits++;
                end
        end

        for (int p = 0; random_hits < RANDOM_HITS; p++)
        begin
            idle_on = (p != 1);
            stall_on = (p != 1);
            if (p == 2)
                run_burst();
            else
                run_phase($urandom_range(60, 30));
        end
        idle_on = 1'b1;
        stall_on = 1'b1;

        hit_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d directed and %0d random hits over %0d window settings",
                 directed_hits, random_hits, window_writes);
        $display("outcomes: %0d new signals, %0d merges, %0d dropped hits",
                 new_count, merged_count, dropped_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
